>>> rtl/hrlf_pkg.sv
// ----------------------------------------------------------------------------
// hrlf_pkg
// Shared types and constants of the request length framer: byte classes,
// parser phases, status codes and the queue entry between front and back.
// ----------------------------------------------------------------------------
package hrlf_pkg;

    localparam int unsigned KEY_LEN   = 15;
    localparam int unsigned KEY_POS_W = 4;

    localparam logic [7:0] KEY_TEXT [0:KEY_LEN-1] = '{
        8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
        8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
    };

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd8191;
    localparam logic [16:0] TARGET_CAP      = 17'h10000;
    localparam logic [15:0] LENGTH_SAT      = 16'hffff;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_SPACE  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_REJECT = 2'd3
    } hrlf_phase_t;

    typedef enum logic [1:0] {
        ST_RECEIVING = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_ERROR     = 2'd2
    } hrlf_status_t;

    typedef struct packed {
        logic                new_request;
        logic                is_cr;
        logic                is_lf;
        logic                is_ws;
        logic                is_digit;
        logic [3:0]          digit;
        logic [KEY_LEN:0]    key_hit;
    } hrlf_item_t;

endpackage

>>> rtl/hrlf_front.sv
// ----------------------------------------------------------------------------
// hrlf_front
// Accepts request bytes, classifies each one and holds the classified
// entries in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
module hrlf_front
    import hrlf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_new_request,
    output logic       q_valid,
    output hrlf_item_t q_item,
    input  logic       q_pop
);

    hrlf_item_t item_in;
    hrlf_item_t mem_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // byte classification
    always_comb begin
        item_in             = '0;
        item_in.new_request = s_new_request;
        item_in.is_cr       = (s_byte_in == CH_CR);
        item_in.is_lf       = (s_byte_in == CH_LF);
        item_in.is_ws       = (s_byte_in == CH_SPACE) || (s_byte_in == CH_TAB);
        item_in.is_digit    = (s_byte_in >= CH_ZERO) && (s_byte_in <= CH_NINE);
        item_in.digit       = 4'(s_byte_in - CH_ZERO);
        for (int k = 0; k < KEY_LEN; k++) begin
            item_in.key_hit[k] = (s_byte_in == KEY_TEXT[k]);
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue did not grow on push");

    a_pop_only_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue did not shrink on pop");

endmodule

>>> rtl/hrlf_back.sv
// ----------------------------------------------------------------------------
// hrlf_back
// Header line parser and body counter. Takes one queued byte per cycle while
// the output is not stalled, and registers the result for the output channel.
// ----------------------------------------------------------------------------
module hrlf_back
    import hrlf_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] max_bytes,
    input  logic        q_valid,
    input  hrlf_item_t  q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_header_end,
    output logic        m_length_seen,
    output logic [15:0] m_body_size,
    output logic [15:0] m_bytes_taken
);

    localparam int unsigned WW = LENGTH_BITS + 4;
    localparam int unsigned EW = LENGTH_BITS + 17;

    logic                   pend_cr_reg, pend_cr_next;
    hrlf_phase_t            phase_reg, phase_next;
    logic [KEY_POS_W-1:0]   pos_reg, pos_next;
    logic                   nonempty_reg, nonempty_next;
    logic                   digit_seen_reg, digit_seen_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   len_taken_reg, len_taken_next;
    logic [LENGTH_BITS-1:0] body_reg, body_next;
    logic                   hdr_end_reg, hdr_end_next;
    logic [15:0]            count_reg, count_next;
    logic [16:0]            target_reg, target_next;
    hrlf_status_t           outcome_reg, outcome_next;

    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic                   out_hdr_reg;
    logic                   out_len_reg;
    logic [15:0]            out_clen_reg, clen_next;
    logic [15:0]            out_bytes_reg;

    logic                   take;
    logic [WW-1:0]          acc_wide;
    logic [EW-1:0]          body_ext;
    logic [16:0]            add17;
    logic [16:0]            total17;

    assign take  = q_valid && (!out_valid_reg || m_ready);
    assign q_pop = take;

    always_comb begin
        pend_cr_next    = pend_cr_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        nonempty_next   = nonempty_reg;
        digit_seen_next = digit_seen_reg;
        acc_next        = acc_reg;
        len_taken_next  = len_taken_reg;
        body_next       = body_reg;
        hdr_end_next    = hdr_end_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        outcome_next    = outcome_reg;
        acc_wide        = '0;
        body_ext        = '0;
        add17           = '0;
        total17         = '0;

        if (q_item.new_request) begin
            pend_cr_next    = 1'b0;
            phase_next      = PH_PREFIX;
            pos_next        = '0;
            nonempty_next   = 1'b0;
            digit_seen_next = 1'b0;
            acc_next        = '0;
            len_taken_next  = 1'b0;
            body_next       = '0;
            hdr_end_next    = 1'b0;
            count_next      = '0;
            target_next     = '0;
            outcome_next    = ST_RECEIVING;
        end

        if (outcome_next == ST_RECEIVING) begin
            count_next = count_next + 16'd1;
            if (!hdr_end_next) begin
                if (pend_cr_next && q_item.is_lf) begin
                    // line end
                    pend_cr_next = 1'b0;
                    if (!nonempty_next) begin
                        body_ext = EW'(body_next);
                        add17 = (body_ext > EW'(TARGET_CAP)) ? TARGET_CAP
                                                             : body_ext[16:0];
                        total17 = {1'b0, count_next} + add17;
                        hdr_end_next = 1'b1;
                        target_next  = total17;
                        if (total17 > {1'b0, max_bytes}) begin
                            outcome_next = ST_ERROR;
                        end
                    end else begin
                        if (!len_taken_next && phase_next == PH_DIGITS
                                && digit_seen_next) begin
                            body_next      = acc_next;
                            len_taken_next = 1'b1;
                        end
                        phase_next      = PH_PREFIX;
                        pos_next        = '0;
                        nonempty_next   = 1'b0;
                        digit_seen_next = 1'b0;
                        acc_next        = '0;
                    end
                end else begin
                    // a held cr that is not followed by lf is a plain char
                    if (pend_cr_next) begin
                        nonempty_next = 1'b1;
                        phase_next    = PH_REJECT;
                    end
                    pend_cr_next = q_item.is_cr;
                    if (!q_item.is_cr) begin
                        nonempty_next = 1'b1;
                        case (phase_next)
                            PH_PREFIX: begin
                                if (pos_next != KEY_POS_W'(KEY_LEN)
                                        && q_item.key_hit[pos_next]) begin
                                    pos_next = pos_next + KEY_POS_W'(1);
                                    if (pos_next == KEY_POS_W'(KEY_LEN)) begin
                                        phase_next = PH_SPACE;
                                    end
                                end else begin
                                    phase_next = PH_REJECT;
                                end
                            end
                            PH_SPACE, PH_DIGITS: begin
                                if (phase_next == PH_SPACE && q_item.is_ws) begin
                                    phase_next = PH_SPACE;
                                end else if (!q_item.is_digit) begin
                                    phase_next = PH_REJECT;
                                end else begin
                                    acc_wide = (WW'(acc_next) << 3)
                                             + (WW'(acc_next) << 1)
                                             + WW'(q_item.digit);
                                    if (acc_wide[WW-1:LENGTH_BITS] != '0) begin
                                        phase_next = PH_REJECT;
                                    end else begin
                                        acc_next        = acc_wide[LENGTH_BITS-1:0];
                                        digit_seen_next = 1'b1;
                                        phase_next      = PH_DIGITS;
                                    end
                                end
                            end
                            default: begin
                                phase_next = PH_REJECT;
                            end
                        endcase
                    end
                end
            end
            if (outcome_next == ST_RECEIVING) begin
                if (hdr_end_next && {1'b0, count_next} >= target_next) begin
                    outcome_next = ST_COMPLETE;
                end else if (count_next >= max_bytes) begin
                    outcome_next = ST_ERROR;
                end
            end
        end

        clen_next = (EW'(body_next) > EW'(LENGTH_SAT)) ? LENGTH_SAT
                                                       : body_next[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cr_reg    <= 1'b0;
            phase_reg      <= PH_PREFIX;
            pos_reg        <= '0;
            nonempty_reg   <= 1'b0;
            digit_seen_reg <= 1'b0;
            acc_reg        <= '0;
            len_taken_reg  <= 1'b0;
            body_reg       <= '0;
            hdr_end_reg    <= 1'b0;
            count_reg      <= '0;
            target_reg     <= '0;
            outcome_reg    <= ST_RECEIVING;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                pend_cr_reg    <= pend_cr_next;
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                nonempty_reg   <= nonempty_next;
                digit_seen_reg <= digit_seen_next;
                acc_reg        <= acc_next;
                len_taken_reg  <= len_taken_next;
                body_reg       <= body_next;
                hdr_end_reg    <= hdr_end_next;
                count_reg      <= count_next;
                target_reg     <= target_next;
                outcome_reg    <= outcome_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            out_status_reg <= outcome_next;
            out_hdr_reg    <= hdr_end_next;
            out_len_reg    <= len_taken_next;
            out_clen_reg   <= clen_next;
            out_bytes_reg  <= count_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_header_end  = out_hdr_reg;
    assign m_length_seen = out_len_reg;
    assign m_body_size   = out_clen_reg;
    assign m_bytes_taken = out_bytes_reg;

    a_complete_needs_headers: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_COMPLETE) |-> m_header_end)
        else $error("complete reported before header end");

    a_no_length_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_length_seen) |-> (m_body_size == '0))
        else $error("content length set without length line");

    a_held_after_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !q_item.new_request && outcome_reg != ST_RECEIVING)
            |=> $stable(count_reg))
        else $error("byte counted after outcome");

    a_digits_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DIGITS) |-> digit_seen_reg)
        else $error("digit phase without a digit");

endmodule

>>> rtl/http_request_length_framer_top.sv
// ----------------------------------------------------------------------------
// http_request_length_framer_top
// Frames one request per byte stream by its content length line.
// The byte is held in the queue, then the parser registers the result for it.
// Throughput: one byte per cycle while the output is not stalled, bound by the parser update.
// Reset clears queue, parser and output, and sets the size limit to 8191.
// ----------------------------------------------------------------------------
module http_request_length_framer_top
    import hrlf_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_new_request,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_header_end,
    output logic        m_length_seen,
    output logic [15:0] m_body_size,
    output logic [15:0] m_bytes_taken
);

    logic [15:0] max_bytes_reg, max_bytes_next;
    logic        q_valid;
    logic        q_pop;
    hrlf_item_t  q_item;

    assign max_bytes_next = cfg_wr_en ? cfg_wr_data : max_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else begin
            max_bytes_reg <= max_bytes_next;
        end
    end

    hrlf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_new_request (s_new_request),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    hrlf_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_bytes     (max_bytes_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_header_end  (m_header_end),
        .m_length_seen (m_length_seen),
        .m_body_size   (m_body_size),
        .m_bytes_taken (m_bytes_taken)
    );

endmodule

>>> bench/http_request_length_framer_top_tb.sv
// ----------------------------------------------------------------------------
// http_request_length_framer_top_tb
// Self-checking bench for the request length framer. Request bytes go in
// through the valid/ready input channel, with random gaps and one long
// output stall. A bit-exact predictor runs on every byte transfer and each
// result transfer is checked field by field against it. Directed requests
// cover the length line forms, digit overflow, saturation, the size limit
// and its extremes; random well-formed, broken and noise requests follow
// under several limit settings.
// ----------------------------------------------------------------------------
module http_request_length_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlf_pkg::*;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned END_CYCLES   = 16;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam logic [63:0] LENGTH_MAX   = '1;
    localparam string       CRLF         = "\015\012";

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        hrlf_status_t status;
        logic         header_end;
        logic         length_seen;
        logic [15:0]  body_size;
        logic [15:0]  bytes_taken;
    } framing_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in     = '0;
    logic        s_new_request = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic        m_header_end;
    logic        m_length_seen;
    logic [15:0] m_body_size;
    logic [15:0] m_bytes_taken;

    framing_result_t expected_results [$];

    int unsigned mismatches      = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned requests_done   = 0;
    int unsigned requests_failed = 0;
    int unsigned limit_writes    = 0;
    int unsigned cycle_count     = 0;
    bit          sender_burst    = 1'b0;
    bit          hold_request    = 1'b0;
    bit          hold_active     = 1'b0;

    // predictor state
    logic [15:0]  mirror_limit;
    logic         pend_cr;
    hrlf_phase_t  line_phase;
    int unsigned  key_pos;
    logic         line_used;
    logic         got_digit;
    logic [63:0]  digit_acc;
    logic         length_taken;
    logic [63:0]  body_len;
    logic         hdr_end;
    logic [15:0]  byte_count;
    logic [16:0]  target_total;
    hrlf_status_t outcome;

    always #(CLK_HALF) aclk = ~aclk;

    http_request_length_framer_top #(
        .LENGTH_BITS(64)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_new_request (s_new_request),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_header_end  (m_header_end),
        .m_length_seen (m_length_seen),
        .m_body_size   (m_body_size),
        .m_bytes_taken (m_bytes_taken)
    );

    function automatic void clear_line_state();
        line_phase = PH_PREFIX;
        key_pos    = 0;
        line_used  = 1'b0;
        got_digit  = 1'b0;
        digit_acc  = '0;
    endfunction

    function automatic void clear_request_state();
        pend_cr = 1'b0;
        clear_line_state();
        length_taken = 1'b0;
        body_len     = '0;
        hdr_end      = 1'b0;
        byte_count   = '0;
        target_total = '0;
        outcome      = ST_RECEIVING;
    endfunction

    function automatic void take_line_char(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - CH_ZERO};
        line_used = 1'b1;
        if (line_phase == PH_PREFIX) begin
            if (key_pos < KEY_LEN && c == KEY_TEXT[key_pos]) begin
                key_pos++;
                if (key_pos == KEY_LEN) begin
                    line_phase = PH_SPACE;
                end
            end else begin
                line_phase = PH_REJECT;
            end
        end else if (line_phase == PH_SPACE || line_phase == PH_DIGITS) begin
            if (!(line_phase == PH_SPACE && (c == CH_SPACE || c == CH_TAB))) begin
                if (c < CH_ZERO || c > CH_NINE) begin
                    line_phase = PH_REJECT;
                end else if (digit_acc > (LENGTH_MAX - d) / 64'd10) begin
                    line_phase = PH_REJECT;
                end else begin
                    digit_acc  = digit_acc * 64'd10 + d;
                    got_digit  = 1'b1;
                    line_phase = PH_DIGITS;
                end
            end
        end
    endfunction

    function automatic void take_line_end();
        logic [63:0] add;
        logic [63:0] total;
        if (!line_used) begin
            add          = (body_len > 64'd65536) ? 64'd65536 : body_len;
            total        = {48'd0, byte_count} + add;
            hdr_end      = 1'b1;
            target_total = total[16:0];
            if (total > {48'd0, mirror_limit}) begin
                outcome = ST_ERROR;
            end
        end else begin
            if (!length_taken && line_phase == PH_DIGITS && got_digit) begin
                body_len     = digit_acc;
                length_taken = 1'b1;
            end
            clear_line_state();
        end
    endfunction

    function automatic framing_result_t frame_byte(logic [7:0] c, logic nr);
        framing_result_t r;
        if (nr) begin
            clear_request_state();
        end
        if (outcome == ST_RECEIVING) begin
            byte_count = byte_count + 16'd1;
            if (!hdr_end) begin
                if (pend_cr && c == CH_LF) begin
                    pend_cr = 1'b0;
                    take_line_end();
                end else begin
                    if (pend_cr) begin
                        take_line_char(CH_CR);
                    end
                    pend_cr = (c == CH_CR);
                    if (!pend_cr) begin
                        take_line_char(c);
                    end
                end
            end
            if (outcome == ST_RECEIVING) begin
                if (hdr_end && {1'b0, byte_count} >= target_total) begin
                    outcome = ST_COMPLETE;
                end else if (byte_count >= mirror_limit) begin
                    outcome = ST_ERROR;
                end
            end
        end
        r.status      = outcome;
        r.header_end  = hdr_end;
        r.length_seen = length_taken;
        r.body_size   = (body_len > 64'd65535) ? LENGTH_SAT : body_len[15:0];
        r.bytes_taken = byte_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // prediction on byte transfers, then checking of result transfers
    always @(posedge aclk) begin
        framing_result_t pred;
        framing_result_t want;
        hrlf_status_t    prior;
        if (!aresetn) begin
            mirror_limit = MAX_BYTES_RESET;
            clear_request_state();
        end else begin
            if (cfg_wr_en) begin
                mirror_limit = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                prior = outcome;
                pred  = frame_byte(s_byte_in, s_new_request);
                expected_results.push_back(pred);
                bytes_accepted++;
                if (prior == ST_RECEIVING || s_new_request) begin
                    if (pred.status == ST_COMPLETE) begin
                        requests_done++;
                    end else if (pred.status == ST_ERROR) begin
                        requests_failed++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("header_end", 16'(want.header_end), 16'(m_header_end));
                    check_field("length_seen", 16'(want.length_seen),
                                16'(m_length_seen));
                    check_field("body_size", want.body_size, m_body_size);
                    check_field("bytes_taken", want.bytes_taken, m_bytes_taken);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // receiver: random ready pattern, plus a long hold-off on request
    initial begin : result_sink
        int unsigned run;
        int unsigned gap;
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active  = 1'b0;
                hold_request = 1'b0;
            end
            m_ready <= 1'b1;
            run = $urandom_range(1, 80);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic nr);
        int unsigned gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_byte_in     <= b;
        s_new_request <= nr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text(string s, logic nr_first);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], nr_first && i == 0);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [15:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_writes++;
    endtask

    function automatic void append_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
    endfunction

    function automatic void append_token(ref byte_q_t q, input int unsigned len);
        repeat (len) q.push_back(8'($urandom_range(33, 126)));
    endfunction

    function automatic void append_length_line(ref byte_q_t q, input logic [63:0] value);
        append_text(q, "Content-Length:");
        repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        append_text(q, $sformatf("%0d", value));
        append_text(q, CRLF);
    endfunction

    function automatic byte_q_t build_request();
        byte_q_t     msg;
        int unsigned n_lines;
        int unsigned len_pos;
        bit          with_len;
        logic [63:0] blen;
        msg      = {};
        n_lines  = $urandom_range(0, 2);
        len_pos  = $urandom_range(0, n_lines);
        with_len = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 3))
                0: blen = 64'd65535;
                1: blen = 64'd65536;
                2: blen = 64'($urandom_range(41, 70000));
                default: blen = LENGTH_MAX;
            endcase
        end else begin
            blen = 64'($urandom_range(0, 24));
        end
        append_token(msg, $urandom_range(1, 8));
        append_text(msg, CRLF);
        for (int unsigned i = 0; i <= n_lines; i++) begin
            if (with_len && i == len_pos) begin
                append_length_line(msg, blen);
                if ($urandom_range(0, 4) == 0) begin
                    append_length_line(msg, 64'($urandom_range(0, 99)));
                end
            end
            if (i < n_lines) begin
                append_token(msg, $urandom_range(1, 10));
                append_text(msg, CRLF);
            end
        end
        append_text(msg, CRLF);
        if (with_len && blen <= 64'd40) begin
            repeat (int'(blen)) msg.push_back(8'($urandom_range(0, 255)));
        end
        return msg;
    endfunction

    task automatic test_plain_requests();
        send_text({"GET / HTTP/1.1", CRLF, "Content-Length: 5", CRLF, CRLF, "hello"}, 1'b1);
        // ignored until the next new request
        send_text("zz", 1'b0);
        send_text(CRLF, 1'b1);
        send_text({"Content-Length:2", CRLF, CRLF}, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
    endtask

    task automatic test_length_line_forms();
        // bare cr inside a line, tab and space, later length line ignored
        send_text({"Host: a\015b", CRLF, "Content-Length:\t 3", CRLF,
                   "Content-Length: 9", CRLF, CRLF, "xyz"}, 1'b1);
        // malformed length lines, then a valid one
        send_text({"content-length: 4", CRLF, "Content-Length: 4x", CRLF,
                   "Content-Length: ", CRLF, "Content-Length:3 ", CRLF,
                   "X\015\015\012", "\012Y", CRLF, "Content-Length:  2", CRLF, CRLF, "ab"},
                  1'b1);
    endtask

    task automatic test_length_extremes();
        write_limit(16'hffff);
        // one past the 64-bit range is dropped, the next line is taken
        send_text({"Content-Length: 18446744073709551616", CRLF,
                   "Content-Length: 7", CRLF, CRLF, "1234567"}, 1'b1);
        send_text({"Content-Length: 18446744073709551615", CRLF, CRLF, "q"}, 1'b1);
        send_text({"Content-Length: 65535", CRLF, CRLF}, 1'b1);
        send_text({"Content-Length: 65536", CRLF, CRLF}, 1'b1);
        send_text({"Content-Length:0", CRLF, CRLF}, 1'b1);
    endtask

    task automatic test_size_limit();
        write_limit(16'd23);
        send_text({"Content-Length:3", CRLF, CRLF, "abc"}, 1'b1);
        send_text({"Content-Length:4", CRLF, CRLF, "abcd"}, 1'b1);
        send_text({"Header-Without-An-End-Line", CRLF}, 1'b1);
        write_limit(16'd0);
        send_text("ab", 1'b1);
        write_limit(16'd1);
        send_text("cd", 1'b1);
    endtask

    task automatic test_limit_lowered();
        write_limit(MAX_BYTES_RESET);
        send_text({"GET /x HTTP/1.1", CRLF}, 1'b1);
        write_limit(16'd5);
        send_text("Yz", 1'b0);
        write_limit(MAX_BYTES_RESET);
        send_text({"Content-Length: 9", CRLF, "AB"}, 1'b1);
        // restart in the middle of a request
        send_text({CRLF, "ok"}, 1'b1);
    endtask

    task automatic test_output_stall();
        wait_drained();
        hold_request = 1'b1;
        wait (hold_active);
        sender_burst = 1'b1;
        send_text({"POST /fill HTTP/1.1", CRLF, "X-Fill: aaaa", CRLF,
                   "Content-Length: 4", CRLF, CRLF, "done"}, 1'b1);
        sender_burst = 1'b0;
    endtask

    task automatic test_random_phase(logic [15:0] limit, int unsigned byte_budget);
        byte_q_t     msg;
        int unsigned sent;
        int unsigned kind;
        int          mid_at;
        bit          nr_first;
        write_limit(limit);
        sent = 0;
        while (sent < byte_budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 90) begin
                msg = build_request();
                if (kind >= 75) begin
                    case ($urandom_range(0, 2))
                        0: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
                        1: msg.insert($urandom_range(0, msg.size() - 1), CH_CR);
                        default: msg = msg[0:$urandom_range(0, msg.size() - 1)];
                    endcase
                end
            end else begin
                msg = {};
                repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom_range(0, 255)));
            end
            nr_first     = ($urandom_range(0, 19) != 0);
            mid_at       = ($urandom_range(0, 19) == 0) ? $urandom_range(1, msg.size()) : -1;
            sender_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < msg.size(); i++) begin
                send_byte(msg[i], (nr_first && i == 0) || i == mid_at);
            end
            sender_burst = 1'b0;
            sent += msg.size();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_requests();
        test_length_line_forms();
        test_length_extremes();
        test_size_limit();
        test_limit_lowered();
        test_output_stall();
        test_random_phase(MAX_BYTES_RESET, 25);
        test_random_phase(16'd48, 15);
        test_random_phase(16'hffff, 15);
        test_random_phase(16'($urandom_range(20, 120)), 15);
        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        $display("framer run: %0d bytes transferred, %0d requests completed, %0d failed",
                 bytes_accepted, requests_done, requests_failed);
        $display("size limit written %0d times, %0d result mismatches",
                 limit_writes, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
